### rtl/cse_pkg.sv
// Package for the CAN signal extract and scale block.
// Holds the channel payload types, the register set and shared helpers.
// Used by every module in this folder; depends on nothing else.
package cse_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int DATA_W      = 64;
   localparam int ID_W        = 29;
   localparam int LEN_W       = 4;
   localparam int BITLEN_W    = 7;
   localparam int FACTOR_W    = 32;
   localparam int OFFSET_W    = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   // One partial product: a zero-extended 32-bit half of raw times the factor.
   localparam int PROD_W      = DATA_W / 2 + 1 + FACTOR_W;
   // Full-precision width of raw * factor + offset, with one guard bit.
   localparam int SUM_W       = DATA_W + FACTOR_W + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_ID     = 3'd0,
      CSR_START_BYTE    = 3'd1,
      CSR_START_BIT     = 3'd2,
      CSR_BIT_LENGTH    = 3'd3,
      CSR_LITTLE_ENDIAN = 3'd4,
      CSR_SCALE_FACTOR  = 3'd5,
      CSR_SCALE_OFFSET  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [ID_W-1:0]   frame_id;
      logic [DATA_W-1:0] frame_data;
      logic [LEN_W-1:0]  frame_length;
   } req_type;

   typedef struct packed {
      logic                     id_match;
      logic [DATA_W-1:0]        raw_value;
      logic signed [DATA_W-1:0] scaled_value;
      logic                     short_frame;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]            target_id;
      logic [2:0]                 start_byte;
      logic [2:0]                 start_bit;
      logic [BITLEN_W-1:0]        bit_length;
      logic                       little_endian;
      logic signed [FACTOR_W-1:0] scale_factor;
      logic signed [OFFSET_W-1:0] scale_offset;
   } cfg_type;

   // Extracted signal handed from the extract pipeline to the scale pipeline.
   typedef struct packed {
      logic              id_match;
      logic              short_frame;
      logic [DATA_W-1:0] raw_value;
   } raw_type;

   function automatic logic [DATA_W-1:0] reverse_bits(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < DATA_W; i++) begin
         r[i] = v[DATA_W-1-i];
      end
      return r;
   endfunction

endpackage

### rtl/cse_extract.sv
// Two-stage bit-field extractor: identifier match, shift and mask, then reversal.
// Depends on cse_pkg for the payload, configuration and hand-off types.
module cse_extract (
   input  logic             clock,
   input  logic             reset,
   input  cse_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_stall,
   input  cse_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output cse_pkg::raw_type out_data
);

   logic                             v1_ff;
   logic                             v2_ff;
   logic                             en1;
   logic                             en2;

   logic                             match_in, match_ff;
   logic                             short_in, short_ff;
   logic [cse_pkg::BITLEN_W-1:0]     n_in, n_ff;
   logic [cse_pkg::DATA_W-1:0]       bits_in, bits_ff;
   cse_pkg::raw_type                 raw_in, raw_ff;

   logic [cse_pkg::LEN_W-1:0]        flen;
   logic [5:0]                       pos0;
   logic [cse_pkg::BITLEN_W-1:0]     avail;
   logic                             len_ok;
   logic                             start_past;
   logic [cse_pkg::DATA_W-1:0]       mask;
   logic [5:0]                       rshift;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   // Stage 1: match, clamp the frame length, shift the field down and mask it.
   always_comb begin
      flen = (in_data.frame_length > cse_pkg::LEN_W'(cse_pkg::FRAME_BYTES))
             ? cse_pkg::LEN_W'(cse_pkg::FRAME_BYTES) : in_data.frame_length;
      pos0       = {cfg.start_byte, cfg.start_bit};
      avail      = {flen, 3'b000} - {1'b0, pos0};
      len_ok     = (cfg.bit_length >= 7'd1) && (cfg.bit_length <= 7'd64);
      start_past = {1'b0, cfg.start_byte} >= flen;
      match_in   = (in_data.frame_id == cfg.target_id);
      short_in   = 1'b0;
      n_in       = '0;
      if (match_in && len_ok) begin
         if (start_past) begin
            short_in = 1'b1;
         end else if (avail < cfg.bit_length) begin
            short_in = 1'b1;
            n_in     = avail;
         end else begin
            n_in = cfg.bit_length;
         end
      end
      // A shift by 64 gives zero, so the subtraction yields all ones for n = 64.
      mask    = (64'd1 << n_in) - 64'd1;
      bits_in = (in_data.frame_data >> pos0) & mask;
   end

   // Stage 2: in big mode the collected bits are reversed and right-aligned.
   always_comb begin
      rshift = 6'(7'd64 - n_ff);
      raw_in.id_match    = match_ff;
      raw_in.short_frame = short_ff;
      if (cfg.little_endian || n_ff == '0) begin
         raw_in.raw_value = bits_ff;
      end else begin
         raw_in.raw_value = cse_pkg::reverse_bits(bits_ff) >> rshift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         match_ff <= match_in;
         short_ff <= short_in;
         n_ff     <= n_in;
         bits_ff  <= bits_in;
      end
      if (en2) begin
         raw_ff <= raw_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = raw_ff;

endmodule

### rtl/cse_scale.sv
// Three-stage fixed-point scaler: partial products, sum with offset, saturation.
// Depends on cse_pkg for the hand-off, configuration and result types.
module cse_scale (
   input  logic             clock,
   input  logic             reset,
   input  cse_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_stall,
   input  cse_pkg::raw_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output cse_pkg::rsp_type out_data
);

   logic                                v3_ff, v4_ff, v5_ff;
   logic                                en3, en4, en5;

   logic signed [cse_pkg::PROD_W-1:0]   p_lo_in, p_lo_ff;
   logic signed [cse_pkg::PROD_W-1:0]   p_hi_in, p_hi_ff;
   cse_pkg::raw_type                    raw3_ff, raw4_ff;
   logic signed [cse_pkg::SUM_W-1:0]    sum_in, sum_ff;
   cse_pkg::rsp_type                    rsp_in, rsp_ff;
   logic                                ovf;

   assign en5      = !v5_ff || !out_stall;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign in_stall = !en3;

   // Stage 3: each 32-bit half of the unsigned 64-bit raw value times the factor.
   always_comb begin
      p_lo_in = $signed({1'b0, in_data.raw_value[31:0]}) * cfg.scale_factor;
      p_hi_in = $signed({1'b0, in_data.raw_value[63:32]}) * cfg.scale_factor;
   end

   // Stage 4: recombine the halves and add the sign-extended offset exactly.
   always_comb begin
      sum_in = cse_pkg::SUM_W'(p_lo_ff)
             + (cse_pkg::SUM_W'(p_hi_ff) <<< 32)
             + cse_pkg::SUM_W'(cfg.scale_offset);
   end

   // Stage 5: clip to the signed 64-bit range; a miss clears every field.
   always_comb begin
      ovf = (sum_ff[cse_pkg::SUM_W-1:cse_pkg::DATA_W-1] != '0) &&
            (sum_ff[cse_pkg::SUM_W-1:cse_pkg::DATA_W-1] != '1);
      rsp_in.id_match    = raw4_ff.id_match;
      rsp_in.raw_value   = raw4_ff.raw_value;
      rsp_in.short_frame = raw4_ff.short_frame;
      rsp_in.saturated   = ovf;
      if (!ovf) begin
         rsp_in.scaled_value = sum_ff[cse_pkg::DATA_W-1:0];
      end else if (sum_ff[cse_pkg::SUM_W-1]) begin
         rsp_in.scaled_value = {1'b1, {(cse_pkg::DATA_W-1){1'b0}}};
      end else begin
         rsp_in.scaled_value = {1'b0, {(cse_pkg::DATA_W-1){1'b1}}};
      end
      if (!raw4_ff.id_match) begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en3) begin
            v3_ff <= in_valid;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         p_lo_ff <= p_lo_in;
         p_hi_ff <= p_hi_in;
         raw3_ff <= in_data;
      end
      if (en4) begin
         sum_ff  <= sum_in;
         raw4_ff <= raw3_ff;
      end
      if (en5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = rsp_ff;

endmodule

### rtl/can_signal_extract_scale.sv
// CAN signal extract and scale block, a five-stage pipeline.
// Users feed one CAN frame per item on the req_ channel (valid/stall) and
// receive one result per item on the rsp_ channel, in order.
// If the frame identifier equals target_id, one bit field is taken from the
// payload (start byte and bit, length, bit order from the CSRs), then it is
// multiplied by a signed Q16.16 factor and offset by a signed Q32.16 value,
// giving a saturated Q48.16 result. Other frames give an all-zero result.
// Each accepted item passes through the stages in order (extract:
// match and shift, reversal; scale: partial products, sum, saturation).
// Throughput: one item per cycle, limited by nothing but the receiver;
// each stage has its own valid bit, so bubbles are squeezed out.
// When rsp_stall is high the last stage holds its result and the stages
// behind it keep filling; req_stall rises only when every stage is full.
// The csr_ port writes registers by index; write only while no item is in
// flight. Synchronous reset empties the pipeline and loads the register
// defaults: target_id 0, start 0/0, length 8, little endian, factor 1.0,
// offset 0.
// Depends on cse_pkg, cse_extract and cse_scale.
module can_signal_extract_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cse_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cse_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [cse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cse_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cse_pkg::cfg_type cfg_ff;
   logic             mid_valid;
   logic             mid_stall;
   cse_pkg::raw_type mid_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_id     <= '0;
         cfg_ff.start_byte    <= '0;
         cfg_ff.start_bit     <= '0;
         cfg_ff.bit_length    <= 7'd8;
         cfg_ff.little_endian <= 1'b1;
         cfg_ff.scale_factor  <= 32'sd65536;
         cfg_ff.scale_offset  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cse_pkg::CSR_TARGET_ID: begin
               cfg_ff.target_id <= csr_wdata[cse_pkg::ID_W-1:0];
            end
            cse_pkg::CSR_START_BYTE: begin
               cfg_ff.start_byte <= csr_wdata[2:0];
            end
            cse_pkg::CSR_START_BIT: begin
               cfg_ff.start_bit <= csr_wdata[2:0];
            end
            cse_pkg::CSR_BIT_LENGTH: begin
               cfg_ff.bit_length <= csr_wdata[cse_pkg::BITLEN_W-1:0];
            end
            cse_pkg::CSR_LITTLE_ENDIAN: begin
               cfg_ff.little_endian <= csr_wdata[0];
            end
            cse_pkg::CSR_SCALE_FACTOR: begin
               cfg_ff.scale_factor <= csr_wdata[cse_pkg::FACTOR_W-1:0];
            end
            cse_pkg::CSR_SCALE_OFFSET: begin
               cfg_ff.scale_offset <= csr_wdata[cse_pkg::OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   cse_extract u_extract (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (mid_valid),
      .out_stall (mid_stall),
      .out_data  (mid_data)
   );

   cse_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_stall  (mid_stall),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

### rtl/cse_check.sv
// Port-level checker for the CAN signal extract and scale block, with its bind.
// Depends on cse_pkg and on the top level can_signal_extract_scale.
module cse_check (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cse_pkg::rsp_type rsp_data
);

   // The pipeline is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // A frame with another identifier yields an all-zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.id_match |->
         rsp_data.raw_value == '0 && rsp_data.scaled_value == '0 &&
         !rsp_data.short_frame && !rsp_data.saturated)
      else $error("unmatched frame gave a nonzero result");

   // A clipped result sits exactly at one end of the signed range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.scaled_value == {1'b1, {63{1'b0}}} ||
         rsp_data.scaled_value == {1'b0, {63{1'b1}}})
      else $error("saturated result is not a range limit");

endmodule

bind can_signal_extract_scale cse_check u_cse_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
